// File: src/fsne_pkg.sv
package fsne_pkg;

	localparam int BaseLen = 8;
	localparam int ExtLen  = 3;

	localparam logic [7:0] NulChar   = 8'h00;
	localparam logic [7:0] DotChar   = 8'h2E;
	localparam logic [7:0] SpaceChar = 8'h20;
	localparam logic [7:0] LowerA    = 8'h61;
	localparam logic [7:0] LowerZ    = 8'h7A;
	localparam logic [7:0] CaseDelta = 8'h20;

	// one byte step handed to the name accumulator
	typedef struct packed {
		logic       take;
		logic [7:0] code;
	} step_t;

	// finished 8.3 name, first byte of each part in the top bits
	typedef struct packed {
		logic [8*BaseLen-1:0] base;
		logic [8*ExtLen-1:0]  ext;
	} name_t;

	function automatic logic [7:0] upcase(input logic [7:0] c);
		logic [7:0] r;
		r = c;
		if (c >= LowerA && c <= LowerZ) r = c - CaseDelta;
		return r;
	endfunction

endpackage

// File: src/fsne_name_acc.sv
module fsne_name_acc (
	input  logic            clk,
	input  logic            arst_n,
	input  fsne_pkg::step_t step,
	output fsne_pkg::name_t name
);

	logic [1:0] length_seen_q;
	logic       only_dots_q;
	logic       dot_found_q;
	logic [3:0] base_count_q;
	logic [1:0] ext_count_q;
	logic [7:0] base_q [fsne_pkg::BaseLen];
	logic [7:0] ext_q  [fsne_pkg::ExtLen];

	logic       is_end;
	logic       is_dot;
	logic [7:0] up_code;

	assign is_end  = (step.code == fsne_pkg::NulChar);
	assign is_dot  = (step.code == fsne_pkg::DotChar);
	assign up_code = fsne_pkg::upcase(step.code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_seen_q <= '0;
			only_dots_q   <= 1'b1;
			dot_found_q   <= 1'b0;
			base_count_q  <= '0;
			ext_count_q   <= '0;
			for (int i = 0; i < fsne_pkg::BaseLen; i++) base_q[i] <= fsne_pkg::SpaceChar;
			for (int i = 0; i < fsne_pkg::ExtLen; i++) ext_q[i] <= fsne_pkg::SpaceChar;
		end else if (step.take) begin
			if (is_end) begin
				length_seen_q <= '0;
				only_dots_q   <= 1'b1;
				dot_found_q   <= 1'b0;
				base_count_q  <= '0;
				ext_count_q   <= '0;
				for (int i = 0; i < fsne_pkg::BaseLen; i++) base_q[i] <= fsne_pkg::SpaceChar;
				for (int i = 0; i < fsne_pkg::ExtLen; i++) ext_q[i] <= fsne_pkg::SpaceChar;
			end else begin
				if (length_seen_q != 2'd3) length_seen_q <= length_seen_q + 2'd1;
				if (!is_dot) only_dots_q <= 1'b0;
				if (!dot_found_q) begin
					if (is_dot) begin
						dot_found_q <= 1'b1;
					end else if (base_count_q < 4'(fsne_pkg::BaseLen)) begin
						base_q[base_count_q[2:0]] <= up_code;
						base_count_q <= base_count_q + 4'd1;
					end
				end else if (ext_count_q < 2'(fsne_pkg::ExtLen)) begin
					ext_q[ext_count_q] <= up_code;
					ext_count_q <= ext_count_q + 2'd1;
				end
			end
		end
	end

	// "." and ".." pass through as they are
	always_comb begin
		for (int i = 0; i < fsne_pkg::BaseLen; i++)
			name.base[8*(fsne_pkg::BaseLen-1-i) +: 8] = base_q[i];
		for (int i = 0; i < fsne_pkg::ExtLen; i++)
			name.ext[8*(fsne_pkg::ExtLen-1-i) +: 8] = ext_q[i];
		if (only_dots_q && length_seen_q == 2'd1) begin
			name.base = {fsne_pkg::DotChar, {(fsne_pkg::BaseLen-1){fsne_pkg::SpaceChar}}};
			name.ext  = {fsne_pkg::ExtLen{fsne_pkg::SpaceChar}};
		end else if (only_dots_q && length_seen_q == 2'd2) begin
			name.base = {fsne_pkg::DotChar, fsne_pkg::DotChar,
				{(fsne_pkg::BaseLen-2){fsne_pkg::SpaceChar}}};
			name.ext  = {fsne_pkg::ExtLen{fsne_pkg::SpaceChar}};
		end
	end

endmodule

// File: src/fat_short_name_encoder.sv
// channel | handshake            | payload
// --------+----------------------+------------------------------------
// input   | in_valid / in_ready  | char_code[7:0]
// output  | out_valid / out_ready| base_field[63:0], ext_field[23:0]
//
// One byte per cycle sustained while no zero byte waits on a held result. A byte is registered in the input stage,
// then folded into the name state; a zero byte loads the result register.
// Result valid is registered and rises when its zero byte is taken from the input stage.
// arst_n clears the input stage, the result valid and the name state.
// A waiting result stalls only a terminating zero byte and the bytes behind it; name bytes keep
// flowing into the state while the result sits in the output register.
module fat_short_name_encoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] base_field,
	output logic [23:0] ext_field
);

	// input stage
	logic       valid_s1;
	logic [7:0] char_s1;

	// result register
	logic        out_valid_q;
	logic [63:0] base_q;
	logic [23:0] ext_q;

	fsne_pkg::step_t step;
	fsne_pkg::name_t name;

	logic end_s1;
	logic take;

	assign end_s1 = (char_s1 == fsne_pkg::NulChar);
	// a zero byte needs a free result slot; any other byte always goes
	assign take = valid_s1 && (!end_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || take;

	assign step.take = take;
	assign step.code = char_s1;

	fsne_name_acc u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.name   (name)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) char_s1 <= char_code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && end_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && end_s1) begin
			base_q <= name.base;
			ext_q  <= name.ext;
		end
	end

	assign out_valid  = out_valid_q;
	assign base_field = base_q;
	assign ext_field  = ext_q;

endmodule

// File: dv/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fsne_pkg::*;

	// Run length guard, sized for the slowest legal run:
	// ~1675 bytes, each with at most one sender gap, plus per-name
	// receiver stalls and one LongHold hold-off.
	localparam int CycleLimit = 500000;
	localparam int RandBytes  = 1650;
	localparam int LongHold   = 400;

	// one queued input byte; drain_first makes the driver wait until
	// every short name already sent has come back before offering it
	typedef struct {
		logic [7:0] code;
		bit         drain_first;
	} pend_byte_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  char_code = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] base_field;
	logic [23:0] ext_field;

	fat_short_name_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.base_field (base_field),
		.ext_field  (ext_field)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	pend_byte_t pend[$];
	name_t      expected_names[$];

	// ------------------------------------------------------------------
	// Short-name predictor: mirrors the accumulator state of the block.
	// ------------------------------------------------------------------
	logic [1:0]  name_len;   // bytes seen, sticks at 3
	logic        all_dots;   // nothing but dots so far
	logic        seen_dot;   // first dot passed, now filling extension
	logic [3:0]  base_n;
	logic [1:0]  ext_n;
	logic [63:0] base_acc;
	logic [23:0] ext_acc;

	int err_cnt = 0;
	int bytes_sent = 0;
	int names_checked = 0;
	int dot_names = 0;
	int long_parts = 0;

	function automatic void clear_name();
		name_len = 2'd0;
		all_dots = 1'b1;
		seen_dot = 1'b0;
		base_n   = 4'd0;
		ext_n    = 2'd0;
		base_acc = {BaseLen{SpaceChar}};
		ext_acc  = {ExtLen{SpaceChar}};
	endfunction

	function automatic logic [7:0] to_upper_ascii(input logic [7:0] c);
		if (c >= LowerA && c <= LowerZ) return c - CaseDelta;
		return c;
	endfunction

	function automatic void fold_char(input logic [7:0] c);
		name_t done;
		if (c == NulChar) begin
			done.base = base_acc;
			done.ext  = ext_acc;
			// "." and ".." pass through untouched; note ".." would otherwise
			// put its second dot into the extension
			if (all_dots && name_len == 2'd1) begin
				done.base = {DotChar, {(BaseLen-1){SpaceChar}}};
				done.ext  = {ExtLen{SpaceChar}};
				dot_names++;
			end else if (all_dots && name_len == 2'd2) begin
				done.base = {DotChar, DotChar, {(BaseLen-2){SpaceChar}}};
				done.ext  = {ExtLen{SpaceChar}};
				dot_names++;
			end
			expected_names.push_back(done);
			clear_name();
		end else begin
			if (name_len != 2'd3) name_len++;
			if (c != DotChar) all_dots = 1'b0;
			if (!seen_dot) begin
				if (c == DotChar) begin
					seen_dot = 1'b1;
				end else if (base_n < BaseLen) begin
					base_acc[8*(BaseLen-1-base_n) +: 8] = to_upper_ascii(c);
					base_n++;
				end else begin
					long_parts++;
				end
			end else if (ext_n < ExtLen) begin
				ext_acc[8*(ExtLen-1-ext_n) +: 8] = to_upper_ascii(c);
				ext_n++;
			end else begin
				long_parts++;
			end
		end
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic void queue_byte(input logic [7:0] c, input bit drain);
		pend_byte_t p;
		p.code = c;
		p.drain_first = drain;
		pend.push_back(p);
	endfunction

	// whole name plus terminating zero
	function automatic void queue_name(input string s, input bit drain);
		for (int i = 0; i < s.len(); i++) queue_byte(s[i], drain && i == 0);
		queue_byte(NulChar, drain && s.len() == 0);
	endfunction

	// mostly filename-ish characters, sometimes any nonzero byte
	function automatic logic [7:0] pick_name_char(input int dot_pct);
		int r;
		r = $urandom_range(99);
		if (r < dot_pct) return DotChar;
		if (r < 45) return 8'($urandom_range(LowerZ, LowerA));
		if (r < 65) return 8'($urandom_range(8'h5A, 8'h41));
		if (r < 75) return 8'($urandom_range(8'h39, 8'h30));
		return 8'($urandom_range(255, 1));
	endfunction

	// ------------------------------------------------------------------
	// Driver: one byte transaction at a time from pend, random gaps.
	// idle_pct shifts every 150 bytes, so there are stretches with no
	// gaps at all and stretches with many.
	// ------------------------------------------------------------------
	int gap_left = 0;
	int idle_pct = 0;

	function automatic int pick_gap();
		if ($urandom_range(99) >= idle_pct) return 0;
		if ($urandom_range(9) == 0) return $urandom_range(40, 10);
		return $urandom_range(3, 1);
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				fold_char(char_code);
				bytes_sent++;
				if (bytes_sent % 150 == 0) begin
					case ($urandom_range(2))
						0: idle_pct = 0;
						1: idle_pct = 25;
						default: idle_pct = 60;
					endcase
				end
			end
			// slot is free: previous byte taken or nothing offered
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pend.size() != 0 &&
						!(pend[0].drain_first && expected_names.size() != 0)) begin
					in_valid  <= 1'b1;
					char_code <= pend[0].code;
					void'(pend.pop_front());
					gap_left = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor / receiver: checks each result transaction against the
	// oldest predicted name, drives out_ready with random stalls and one
	// long hold-off so the block backs up and stalls a zero byte.
	// ------------------------------------------------------------------
	int  stall_left = 0;
	int  stall_pct = 0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;

	function automatic int pick_stall();
		if ($urandom_range(99) >= stall_pct) return 0;
		if ($urandom_range(9) == 0) return $urandom_range(40, 10);
		return $urandom_range(3, 1);
	endfunction

	task automatic check_result();
		name_t want;
		if (expected_names.size() == 0) begin
			err_cnt++;
			$display("%0t: unexpected result base=%h ext=%h", $time, base_field, ext_field);
		end else begin
			want = expected_names.pop_front();
			if (base_field !== want.base) begin
				err_cnt++;
				$display("%0t: base_field expected %h got %h", $time, want.base, base_field);
			end
			if (ext_field !== want.ext) begin
				err_cnt++;
				$display("%0t: ext_field expected %h got %h", $time, want.ext, ext_field);
			end
			names_checked++;
			if (names_checked % 20 == 0) stall_pct = $urandom_range(2) * 30;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) check_result();
			if (!hold_done && names_checked == 40) begin
				hold_left = LongHold;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall_left = pick_stall();
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog
	// ------------------------------------------------------------------
	int cycle_cnt = 0;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CycleLimit) begin
			$display("tb_top: timeout after %0d cycles", cycle_cnt);
			$display("tb_top: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of test
	// ------------------------------------------------------------------
	initial begin
		int  kind;
		int  n;
		int  name_idx;
		bit  drain;
		int  dir_bytes;

		clear_name();

		// directed: empty, the two dot names, case edges with base
		// overflow, leading dot with later dot and ext overflow, odd bytes
		queue_name("", 1'b0);
		queue_name(".", 1'b0);
		queue_name("..", 1'b0);
		queue_name("`az{AZ~9q", 1'b0);
		queue_name(".m.qz", 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(DotChar, 1'b0);
		queue_byte(8'h80, 1'b0);
		queue_byte(8'h01, 1'b0);
		queue_byte(NulChar, 1'b0);
		dir_bytes = pend.size();

		// random names: mostly well formed, some dot-only, some noise;
		// every so often a name waits for the pipe to drain first
		name_idx = 0;
		while (pend.size() < dir_bytes + RandBytes) begin
			kind  = $urandom_range(99);
			drain = (name_idx % 45 == 10);
			if (kind < 8) begin
				n = $urandom_range(4, 1);
				for (int i = 0; i < n; i++) queue_byte(DotChar, drain && i == 0);
				queue_byte(NulChar, 1'b0);
			end else if (kind < 78) begin
				n = $urandom_range(10, 0);
				for (int i = 0; i < n; i++) queue_byte(pick_name_char(0), drain && i == 0);
				if ($urandom_range(3) != 0) begin
					queue_byte(DotChar, drain && n == 0);
					n = $urandom_range(5, 0);
					for (int i = 0; i < n; i++) queue_byte(pick_name_char(10), 1'b0);
					queue_byte(NulChar, 1'b0);
				end else begin
					queue_byte(NulChar, drain && n == 0);
				end
			end else begin
				n = $urandom_range(14, 0);
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(4) == 0) queue_byte(DotChar, drain && i == 0);
					else queue_byte(8'($urandom_range(255, 1)), drain && i == 0);
				end
				queue_byte(NulChar, drain && n == 0);
			end
			name_idx++;
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pend.size() != 0 || in_valid) @(posedge clk);
		while (expected_names.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("tb_top: %0d bytes in, %0d short names compared, %0d dot names",
			bytes_sent, names_checked, dot_names);
		$display("tb_top: %0d overflow bytes dropped, %0d mismatches", long_parts, err_cnt);
		if (err_cnt == 0) begin
			$display("tb_top: done, clean");
		end else begin
			$display("tb_top: done, errors");
		end
		$finish;
	end

endmodule

`default_nettype wire

// File: filelist.f
src/fsne_pkg.sv
src/fsne_name_acc.sv
src/fat_short_name_encoder.sv
dv/tb_top.sv
